@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the line pixel generator RTL.
// Each check samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset.
`define LPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never shows up at a clock edge out of reset.
`define LPG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define LPG_ASSERT(label, prop, msg)
`define LPG_NEVER(label, cond, msg)

`endif

`endif

@@ rtl/core/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types for the line pixel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpg_pkg;

    // Sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } lpg_state_t;

    // Walk orientation, set once per line
    typedef struct packed
    {
        logic axes_swapped;
        logic minor_step_down;
    } lpg_orient_t;

endpackage

@@ rtl/core/line_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// Bresenham line rasterizer: one line request in, one word per pixel out.
// ----------------------------------------------------------------------------
// A request word carries two endpoints and a BGRA color. The core walks the
// line along its major axis (y when the line is steeper than 45 degrees, x
// otherwise, ordered to run upward) and emits one pixel word per major step,
// with last_pixel set on the final one. The far endpoint is not drawn, so a
// zero-length line emits no words. A request is taken only while the core is
// idle: it is latched, set up, then walked at one pixel per cycle unless the
// output stalls; a line has up to 2^COORD_BITS - 1 pixels. The walk is paced by
// the single shared step unit that updates the error term once per pixel.
// Downstream stall holds the walk; the last pixel word may still sit in the
// output register while the next request is latched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module line_pixel_generator_core #(
    parameter int COORD_BITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // Request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [31:0]           pixel_color,

    // Pixel channel
    output logic                  pix_valid,
    input  logic                  pix_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [31:0]           out_color,
    output logic                  last_pixel
);

    localparam int ERR_BITS = COORD_BITS + 3;

    // Sequencer
    lpg_pkg::lpg_state_t state_reg;
    lpg_pkg::lpg_state_t state_next;

    // Latched request
    logic [COORD_BITS-1:0] ax_reg;
    logic [COORD_BITS-1:0] ay_reg;
    logic [COORD_BITS-1:0] bx_reg;
    logic [COORD_BITS-1:0] by_reg;
    logic [31:0]           color_reg;

    // Walk state
    logic [COORD_BITS-1:0]      major_pos_reg;
    logic [COORD_BITS-1:0]      minor_pos_reg;
    logic [COORD_BITS-1:0]      major_end_reg;
    logic signed [ERR_BITS-1:0] error_reg;
    logic [COORD_BITS:0]        tmin_reg;
    logic [COORD_BITS:0]        tmaj_reg;
    lpg_pkg::lpg_orient_t       orient_reg;

    // Output register
    logic                  pix_valid_reg;
    logic                  pix_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [31:0]           out_color_reg;
    logic                  last_pixel_reg;

    // Setup results
    logic [COORD_BITS-1:0] su_major_start;
    logic [COORD_BITS-1:0] su_minor_start;
    logic [COORD_BITS-1:0] su_major_end;
    logic [COORD_BITS:0]   su_tmin;
    logic [COORD_BITS:0]   su_tmaj;
    lpg_pkg::lpg_orient_t  su_orient;
    logic                  su_nonzero;

    // Step results
    logic signed [ERR_BITS-1:0] st_error;
    logic [COORD_BITS-1:0]      st_major;
    logic [COORD_BITS-1:0]      st_minor;
    logic                       st_last;

    logic req_take;
    logic pix_take;
    logic pix_load;
    logic do_setup;

    lpg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .ax                (ax_reg),
        .ay                (ay_reg),
        .bx                (bx_reg),
        .by                (by_reg),
        .major_start       (su_major_start),
        .minor_start       (su_minor_start),
        .major_end         (su_major_end),
        .twice_minor_delta (su_tmin),
        .twice_major_delta (su_tmaj),
        .orient            (su_orient),
        .nonzero           (su_nonzero)
    );

    lpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .error_acc         (error_reg),
        .major_pos         (major_pos_reg),
        .minor_pos         (minor_pos_reg),
        .major_end         (major_end_reg),
        .twice_minor_delta (tmin_reg),
        .twice_major_delta (tmaj_reg),
        .minor_step_down   (orient_reg.minor_step_down),
        .error_next        (st_error),
        .major_next        (st_major),
        .minor_next        (st_minor),
        .last              (st_last)
    );

    // Take requests only when idle; pixel words advance when the output
    // register is empty or being drained this cycle.
    assign req_stall = (state_reg != lpg_pkg::ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign pix_take  = pix_valid_reg && !pix_stall;
    assign pix_load  = (state_reg == lpg_pkg::ST_WALK) && (!pix_valid_reg || !pix_stall);
    assign do_setup  = (state_reg == lpg_pkg::ST_SETUP);

    always_comb
    begin
        state_next     = state_reg;
        pix_valid_next = pix_valid_reg;

        if (pix_take)
        begin
            pix_valid_next = 1'b0;
        end
        if (pix_load)
        begin
            pix_valid_next = 1'b1;
        end

        case (state_reg)
            lpg_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = lpg_pkg::ST_SETUP;
                end
            end
            lpg_pkg::ST_SETUP:
            begin
                // Drop zero-length lines without emitting anything
                state_next = su_nonzero ? lpg_pkg::ST_WALK : lpg_pkg::ST_IDLE;
            end
            lpg_pkg::ST_WALK:
            begin
                if (pix_load && st_last)
                begin
                    state_next = lpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpg_pkg::ST_IDLE;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            ax_reg    <= start_x;
            ay_reg    <= start_y;
            bx_reg    <= end_x;
            by_reg    <= end_y;
            color_reg <= pixel_color;
        end

        if (do_setup)
        begin
            major_pos_reg <= su_major_start;
            minor_pos_reg <= su_minor_start;
            major_end_reg <= su_major_end;
            tmin_reg      <= su_tmin;
            tmaj_reg      <= su_tmaj;
            orient_reg    <= su_orient;
            error_reg     <= '0;
        end
        else if (pix_load)
        begin
            // Advance the walk by one major step
            major_pos_reg <= st_major;
            minor_pos_reg <= st_minor;
            error_reg     <= st_error;
        end

        if (pix_load)
        begin
            pixel_x_reg    <= orient_reg.axes_swapped ? minor_pos_reg : major_pos_reg;
            pixel_y_reg    <= orient_reg.axes_swapped ? major_pos_reg : minor_pos_reg;
            out_color_reg  <= color_reg;
            last_pixel_reg <= st_last;
        end
    end

    assign pix_valid  = pix_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign out_color  = out_color_reg;
    assign last_pixel = last_pixel_reg;

    // The final pixel word of a line returns the sequencer to idle
    `LPG_ASSERT(a_last_to_idle, (pix_load && st_last) |=> (state_reg == lpg_pkg::ST_IDLE), "last pixel did not end the walk")

    // Setup only ever follows a taken request
    `LPG_ASSERT(a_setup_after_req, (state_reg == lpg_pkg::ST_SETUP) |-> $past(req_take), "setup without a request")

    // The walk never reaches the far endpoint
    `LPG_NEVER(a_walk_in_range, (state_reg == lpg_pkg::ST_WALK) && (major_pos_reg >= major_end_reg), "walk ran past the line end")

    // Error term stays within one major delta of zero while walking
    `LPG_NEVER(a_error_bound, (state_reg == lpg_pkg::ST_WALK) && (error_reg > $signed({3'b000, tmaj_reg[COORD_BITS:1]})), "error term out of range")

    // A stalled pixel word is never overwritten
    `LPG_NEVER(a_no_overwrite, pix_load && pix_valid_reg && pix_stall, "pixel word overwritten while stalled")

endmodule

@@ rtl/core/lpg_setup.sv @@
// ----------------------------------------------------------------------------
// lpg_setup
// Line setup: pick the major axis, order the endpoints, derive step sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_setup #(
    parameter int COORD_BITS = 6
) (
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    output logic [COORD_BITS-1:0] major_start,
    output logic [COORD_BITS-1:0] minor_start,
    output logic [COORD_BITS-1:0] major_end,
    output logic [COORD_BITS:0]   twice_minor_delta,
    output logic [COORD_BITS:0]   twice_major_delta,
    output lpg_pkg::lpg_orient_t  orient,
    output logic                  nonzero
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] a_major;
    logic [COORD_BITS-1:0] a_minor;
    logic [COORD_BITS-1:0] b_major;
    logic [COORD_BITS-1:0] b_minor;
    logic [COORD_BITS-1:0] dmaj;
    logic [COORD_BITS-1:0] dmin;
    logic                  swapped;
    logic                  reorder;

    always_comb
    begin
        adx     = (ax > bx) ? (ax - bx) : (bx - ax);
        ady     = (ay > by) ? (ay - by) : (by - ay);
        swapped = (adx < ady);

        a_major = swapped ? ay : ax;
        a_minor = swapped ? ax : ay;
        b_major = swapped ? by : bx;
        b_minor = swapped ? bx : by;

        // Make the major axis run upward
        reorder     = (b_major < a_major);
        major_start = reorder ? b_major : a_major;
        major_end   = reorder ? a_major : b_major;
        minor_start = reorder ? b_minor : a_minor;

        dmaj = major_end - major_start;
        dmin = swapped ? adx : ady;

        orient.axes_swapped    = swapped;
        orient.minor_step_down = reorder ? (a_minor < b_minor) : (b_minor < a_minor);

        twice_major_delta = {dmaj, 1'b0};
        twice_minor_delta = {dmin, 1'b0};
        nonzero           = (dmaj != '0);
    end

endmodule

@@ rtl/core/lpg_step.sv @@
// ----------------------------------------------------------------------------
// lpg_step
// One Bresenham step: error update, minor step decision, major advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_step #(
    parameter int COORD_BITS = 6
) (
    input  logic signed [COORD_BITS+2:0] error_acc,
    input  logic [COORD_BITS-1:0]        major_pos,
    input  logic [COORD_BITS-1:0]        minor_pos,
    input  logic [COORD_BITS-1:0]        major_end,
    input  logic [COORD_BITS:0]          twice_minor_delta,
    input  logic [COORD_BITS:0]          twice_major_delta,
    input  logic                         minor_step_down,
    output logic signed [COORD_BITS+2:0] error_next,
    output logic [COORD_BITS-1:0]        major_next,
    output logic [COORD_BITS-1:0]        minor_next,
    output logic                         last
);

    logic signed [COORD_BITS+2:0] sum;
    logic signed [COORD_BITS+2:0] dmaj_s;
    logic                         take_minor;

    always_comb
    begin
        sum        = error_acc + $signed({2'b00, twice_minor_delta});
        dmaj_s     = $signed({3'b000, twice_major_delta[COORD_BITS:1]});
        take_minor = (sum > dmaj_s);
        error_next = take_minor ? (sum - $signed({2'b00, twice_major_delta})) : sum;

        if (!take_minor)
        begin
            minor_next = minor_pos;
        end
        else if (minor_step_down)
        begin
            minor_next = minor_pos - COORD_BITS'(1);
        end
        else
        begin
            minor_next = minor_pos + COORD_BITS'(1);
        end

        major_next = major_pos + COORD_BITS'(1);
        last       = (major_next == major_end);
    end

endmodule

@@ test/tb_line_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// tb_line_pixel_generator_core
// Self-checking bench for the Bresenham line rasterizer core.
// ----------------------------------------------------------------------------
// Line requests go into a queue. A clocked driver sends them over the request
// channel with random gaps. For every request it accepts, a local Bresenham
// walk predicts the pixel words. A clocked monitor stalls the pixel channel at
// random and checks each pixel word against the oldest predicted one. The run
// starts with hand-picked lines and then sends random ones. Near the end the
// gaps and stalls stop. A watchdog ends the run if the channels go quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_pixel_generator_core;

    localparam int CB             = 6;     // coordinate width of the core
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
    localparam int SETTLE_CYCLES  = 70;    // longest line plus setup
    localparam int RANDOM_LINES   = 82;
    localparam int TAIL_LINES     = 15;    // sent with no gaps or stalls

    typedef struct packed
    {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
        logic [31:0]   color;
        bit            wait_drain;  // hold until every pixel word is back
        bit            tail;        // first line of the quiet tail
    } line_req_t;

    typedef struct packed
    {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [31:0]   color;
        logic          last;
    } pixel_word_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;

    logic          req_valid = 1'b0;
    logic          req_stall;
    logic [CB-1:0] start_x = '0;
    logic [CB-1:0] start_y = '0;
    logic [CB-1:0] end_x = '0;
    logic [CB-1:0] end_y = '0;
    logic [31:0]   pixel_color = '0;

    logic          pix_valid;
    logic          pix_stall = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic [31:0]   out_color;
    logic          last_pixel;

    line_req_t     line_queue[$];   // requests not yet sent
    pixel_word_t   pixels_due[$];   // predicted pixel words, oldest first
    line_req_t     cur_req;         // request now on the request channel
    int            send_gap = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;    // no gaps, no stalls once set
    int            fail_count = 0;
    int            idle_cycles = 0;

    line_pixel_generator_core #(
        .COORD_BITS (CB)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .pixel_color (pixel_color),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .out_color   (out_color),
        .last_pixel  (last_pixel)
    );

    always #4 clk = ~clk;

    // Walk the line the way the core should and queue one word per pixel.
    // The major axis is y only when the line is strictly steeper than 45
    // degrees; the walk always runs upward and stops short of the far end.
    function automatic void predict_line(line_req_t r);
        int            adx;
        int            ady;
        int            a_maj;
        int            a_min;
        int            b_maj;
        int            b_min;
        int            tmp;
        int            d_maj;
        int            d_min;
        int            err;
        bit            steep;
        bit            step_down;
        logic [CB-1:0] maj_pos;
        logic [CB-1:0] min_pos;
        pixel_word_t   w;

        adx = (r.sx > r.ex) ? r.sx - r.ex : r.ex - r.sx;
        ady = (r.sy > r.ey) ? r.sy - r.ey : r.ey - r.sy;
        steep = adx < ady;
        if (steep)
        begin
            a_maj = r.sy; a_min = r.sx; b_maj = r.ey; b_min = r.ex;
        end
        else
        begin
            a_maj = r.sx; a_min = r.sy; b_maj = r.ex; b_min = r.ey;
        end
        if (b_maj < a_maj)
        begin
            tmp = a_maj; a_maj = b_maj; b_maj = tmp;
            tmp = a_min; a_min = b_min; b_min = tmp;
        end
        d_maj = b_maj - a_maj;
        d_min = (b_min > a_min) ? b_min - a_min : a_min - b_min;
        step_down = b_min < a_min;
        maj_pos = a_maj[CB-1:0];
        min_pos = a_min[CB-1:0];
        err = 0;
        // A zero-length line falls straight through and predicts nothing.
        for (int i = 0; i < d_maj; i++)
        begin
            w.x     = steep ? min_pos : maj_pos;
            w.y     = steep ? maj_pos : min_pos;
            w.color = r.color;
            w.last  = (i == d_maj - 1);
            pixels_due.push_back(w);
            err += 2 * d_min;
            if (err > d_maj)
            begin
                min_pos = step_down ? min_pos - 1'b1 : min_pos + 1'b1;
                err -= 2 * d_maj;
            end
            maj_pos = maj_pos + 1'b1;
        end
    endfunction

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [31:0] color, input bit wait_drain = 1'b0,
                            input bit tail = 1'b0);
        line_req_t r;
        r.sx         = sx[CB-1:0];
        r.sy         = sy[CB-1:0];
        r.ex         = ex[CB-1:0];
        r.ey         = ey[CB-1:0];
        r.color      = color;
        r.wait_drain = wait_drain;
        r.tail       = tail;
        line_queue.push_back(r);
    endtask

    task automatic flag_error(input string what, input pixel_word_t want,
                              input pixel_word_t got);
        if (fail_count < 10)
            $display("ERROR %s: want x=%0d y=%0d c=%h l=%0b, got x=%0d y=%0d c=%h l=%0b",
                     what, want.x, want.y, want.color, want.last,
                     got.x, got.y, got.color, got.last);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Predict on acceptance, then pick the next step: hold a stalled word,
    // sit out a gap, or present the next request. A request marked to wait
    // for the drain stays back until every predicted pixel word has arrived.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predict_line(cur_req);
                if (!quiet && $urandom_range(0, 2) == 0)
                    send_gap = $urandom_range(1, 12);
            end

            if (req_valid && req_stall)
            begin
                // hold the word and its valid until the core takes it
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (line_queue.size() > 0 &&
                     !(line_queue[0].wait_drain && pixels_due.size() != 0))
            begin
                cur_req = line_queue.pop_front();
                if (cur_req.tail)
                    quiet <= 1'b1;
                start_x     <= cur_req.sx;
                start_y     <= cur_req.sy;
                end_x       <= cur_req.ex;
                end_y       <= cur_req.ey;
                pixel_color <= cur_req.color;
                req_valid   <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel monitor
    // ------------------------------------------------------------------------
    // Check every accepted pixel word against the oldest prediction, then
    // choose the stall for the next cycle in random bursts.
    always @(posedge clk)
    begin
        pixel_word_t got;
        pixel_word_t want;
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                got.x     = pixel_x;
                got.y     = pixel_y;
                got.color = out_color;
                got.last  = last_pixel;
                if (pixels_due.size() == 0)
                begin
                    want = '0;
                    flag_error("unexpected pixel word", want, got);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.color !== want.color || got.last !== want.last)
                        flag_error("pixel mismatch", want, got);
                end
            end

            if (stall_left > 0)
            begin
                stall_left--;
                pix_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                pix_stall <= 1'b1;
            end
            else
            begin
                pix_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which no word moves on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (pix_valid && !pix_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int sx;
        int sy;
        int ex;
        int ey;

        // Zero-length lines at both corners: no pixel words at all.
        add_line(0, 0, 0, 0, 32'h0000_0000);
        add_line(63, 63, 63, 63, 32'hFFFF_FFFF);
        // Full-length axis lines, both directions.
        add_line(0, 0, 63, 0, 32'hFFFF_FFFF);
        add_line(63, 63, 0, 63, 32'hAAAA_5555);
        add_line(0, 0, 0, 63, 32'h5555_AAAA);
        add_line(5, 63, 5, 0, 32'h0000_0000);
        // Exact diagonals keep x as the major axis.
        add_line(0, 0, 63, 63, 32'h1234_5678);
        add_line(63, 0, 0, 63, 32'h8765_4321);
        add_line(0, 63, 63, 0, 32'hFFFF_FFFF);
        // Steep lines, minor stepping up and down.
        add_line(10, 0, 20, 63, 32'hAAAA_5555);
        add_line(10, 63, 20, 0, 32'h5555_AAAA);
        // Shallow lines, minor stepping up and down.
        add_line(0, 10, 63, 20, 32'hDEAD_BEEF);
        add_line(0, 20, 63, 10, 32'hCAFE_F00D);
        add_line(0, 1, 63, 0, 32'h0F0F_0F0F);
        // Single-pixel lines.
        add_line(1, 1, 2, 2, 32'hF0F0_F0F0);
        add_line(7, 7, 8, 7, 32'h0000_0001);
        add_line(3, 4, 3, 5, 32'h8000_0000);
        // Let the pixel channel drain completely before this one.
        add_line(42, 21, 21, 42, 32'h7FFF_FFFF, 1'b1);

        // Random lines: mostly free endpoints, some short, flat or empty.
        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            sx = $urandom_range(0, 63);
            sy = $urandom_range(0, 63);
            case ($urandom_range(0, 9))
                0:
                begin
                    ex = sx;
                    ey = sy;
                end
                1:
                begin
                    ex = $urandom_range(0, 1) ? sx : $urandom_range(0, 63);
                    ey = (ex == sx) ? $urandom_range(0, 63) : sy;
                end
                2, 3:
                begin
                    ex = $urandom_range(sx > 4 ? sx - 4 : 0, sx < 59 ? sx + 4 : 63);
                    ey = $urandom_range(sy > 4 ? sy - 4 : 0, sy < 59 ? sy + 4 : 63);
                end
                default:
                begin
                    ex = $urandom_range(0, 63);
                    ey = $urandom_range(0, 63);
                end
            endcase
            add_line(sx, sy, ex, ey, $urandom, i == RANDOM_LINES / 2,
                     i == RANDOM_LINES - TAIL_LINES);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is taken and every pixel word is back.
        wait (line_queue.size() == 0);
        @(posedge clk);
        while (req_valid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pixels_due.size() != 0)
        begin
            if (fail_count < 10)
                $display("ERROR %0d pixel words never arrived", pixels_due.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ line_pixel_generator_core.f @@
+incdir+rtl/core
rtl/core/lpg_pkg.sv
rtl/core/lpg_setup.sv
rtl/core/lpg_step.sv
rtl/core/line_pixel_generator_core.sv
test/tb_line_pixel_generator_core.sv
